FILE: src/trm_pkg.sv
// trm_pkg: shared types, constants and opcodes of the register machine execute stage.
// No dependencies; every other file of the block imports it.
package trm_pkg;

  localparam int NUM_REGS      = 12;
  localparam int PROGRAM_DEPTH = 256;

  localparam int REG_IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int FIELD_W   = 4;   // register fields of the instruction word
  localparam int DATA_W    = 32;
  localparam int PC_W      = 9;   // counter and program length
  localparam int JT_W      = DATA_W + 2; // signed jump target, no overflow

  typedef enum logic [FIELD_W-1:0] {
    OP_MOV = 4'd0,
    OP_MOC = 4'd1,
    OP_ADD = 4'd2,
    OP_ADC = 4'd3,
    OP_SUB = 4'd4,
    OP_SUC = 4'd5,
    OP_JMP = 4'd6,
    OP_PTN = 4'd7,
    OP_PTC = 4'd8
  } opcode_t;

  typedef enum logic [1:0] {
    PK_NONE = 2'd0,
    PK_NUM  = 2'd1,
    PK_CHAR = 2'd2
  } print_kind_t;

  // register file write request
  typedef struct packed {
    logic               en;
    logic [FIELD_W-1:0] idx;
    logic [DATA_W-1:0]  data;
  } rf_wr_t;

  // outcome of executing one instruction
  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic [1:0]        print_kind;
    logic [DATA_W-1:0] print_value;
    logic              finished;
    logic              fault;
  } exe_res_t;

endpackage

FILE: src/trm_if.sv
// trm_in_if / trm_out_if: valid/ready channels for instructions and results.
// Depends on trm_pkg for field widths.
interface trm_in_if import trm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FIELD_W-1:0]       opcode;
  logic [FIELD_W-1:0]       dest_reg;
  logic [FIELD_W-1:0]       source_reg;
  logic signed [DATA_W-1:0] immediate;

  modport source (output valid, opcode, dest_reg, source_reg, immediate, input ready);
  modport sink   (input valid, opcode, dest_reg, source_reg, immediate, output ready);
endinterface

interface trm_out_if import trm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PC_W-1:0]          next_pc;
  logic [1:0]               print_kind;
  logic signed [DATA_W-1:0] print_value;
  logic                     finished;
  logic                     fault;

  modport source (output valid, next_pc, print_kind, print_value, finished, fault,
                  input ready);
  modport sink   (input valid, next_pc, print_kind, print_value, finished, fault,
                  output ready);
endinterface

FILE: src/trm_regfile.sv
// trm_regfile: general register file, two registered read ports, one write port.
// Depends on trm_pkg. Reads taken in the same cycle as a write see the new value.
module trm_regfile import trm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [FIELD_W-1:0] rd_a_idx,
  input  logic [FIELD_W-1:0] rd_b_idx,
  input  rf_wr_t             wr,
  output logic [DATA_W-1:0]  rd_a,
  output logic [DATA_W-1:0]  rd_b
);

  logic [DATA_W-1:0] rf_r [NUM_REGS];
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;
  logic              wr_ok;
  logic              a_ok;
  logic              b_ok;

  // indexes past the last register read as zero and drop writes
  assign wr_ok = wr.en && ({1'b0, wr.idx} < (FIELD_W+1)'(NUM_REGS));
  assign a_ok  = {1'b0, rd_a_idx} < (FIELD_W+1)'(NUM_REGS);
  assign b_ok  = {1'b0, rd_b_idx} < (FIELD_W+1)'(NUM_REGS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_r[i] <= '0;
      end
    end else if (wr_ok) begin
      rf_r[wr.idx[REG_IDX_W-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (!a_ok) begin
        rd_a_r <= '0;
      end else if (wr_ok && wr.idx == rd_a_idx) begin
        rd_a_r <= wr.data;
      end else begin
        rd_a_r <= rf_r[rd_a_idx[REG_IDX_W-1:0]];
      end
      if (!b_ok) begin
        rd_b_r <= '0;
      end else if (wr_ok && wr.idx == rd_b_idx) begin
        rd_b_r <= wr.data;
      end else begin
        rd_b_r <= rf_r[rd_b_idx[REG_IDX_W-1:0]];
      end
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

FILE: src/trm_alu.sv
// trm_alu: combinational execute of one instruction against the current counter.
// Depends on trm_pkg. Produces the register write and the result fields.
module trm_alu import trm_pkg::*; (
  input  logic [FIELD_W-1:0] opcode,
  input  logic [FIELD_W-1:0] dest_reg,
  input  logic [DATA_W-1:0]  immediate,
  input  logic [DATA_W-1:0]  opnd_a,
  input  logic [DATA_W-1:0]  opnd_b,
  input  logic [PC_W-1:0]    pc,
  input  logic [PC_W-1:0]    len,
  output rf_wr_t             wr,
  output exe_res_t           res
);

  logic                   halted;
  logic [PC_W-1:0]        pc_inc;
  logic signed [JT_W-1:0] target;
  logic signed [JT_W-1:0] len_ext;
  logic [PC_W-1:0]        next_pc;
  logic                   fault;

  assign halted  = pc >= len;
  assign pc_inc  = pc + PC_W'(1);  // pc < len, so no wrap
  assign target  = $signed({{(JT_W-PC_W){1'b0}}, pc})
                 + $signed({{(JT_W-DATA_W){immediate[DATA_W-1]}}, immediate});
  assign len_ext = $signed({{(JT_W-PC_W){1'b0}}, len});

  always_comb begin
    wr.en    = 1'b0;
    wr.idx   = dest_reg;
    wr.data  = '0;
    next_pc  = pc_inc;
    fault    = 1'b0;
    res.print_kind  = PK_NONE;
    res.print_value = '0;
    case (opcode)
      OP_MOV: begin
        wr.en   = 1'b1;
        wr.data = opnd_b;
      end
      OP_MOC: begin
        wr.en   = 1'b1;
        wr.data = immediate;
      end
      OP_ADD: begin
        wr.en   = 1'b1;
        wr.data = opnd_a + opnd_b;
      end
      OP_ADC: begin
        wr.en   = 1'b1;
        wr.data = opnd_a + immediate;
      end
      OP_SUB: begin
        wr.en   = 1'b1;
        wr.data = opnd_a - opnd_b;
      end
      OP_SUC: begin
        wr.en   = 1'b1;
        wr.data = opnd_a - immediate;
      end
      OP_JMP: begin
        if (!opnd_a[DATA_W-1]) begin
          if (target[JT_W-1]) begin
            // target below zero: hold where we are
            fault   = 1'b1;
            next_pc = pc;
          end else if (target > len_ext) begin
            next_pc = len;
          end else begin
            next_pc = target[PC_W-1:0];
          end
        end
      end
      OP_PTN: begin
        res.print_kind  = PK_NUM;
        res.print_value = opnd_a;
      end
      OP_PTC: begin
        res.print_kind  = PK_CHAR;
        res.print_value = {{(DATA_W-8){1'b0}}, opnd_a[7:0]};
      end
      default: begin
      end
    endcase

    if (halted) begin
      wr.en           = 1'b0;
      next_pc         = pc;
      fault           = 1'b0;
      res.print_kind  = PK_NONE;
      res.print_value = '0;
    end

    res.next_pc  = next_pc;
    res.finished = next_pc >= len;
    res.fault    = fault;
  end

endmodule

FILE: src/toy_register_machine_execute.sv
// Execute stage of a small register machine: one instruction in, one result out.
// Depends on trm_pkg, trm_if, trm_regfile and trm_alu. With both sides flowing it
// takes one instruction per cycle: the operand read is registered on acceptance,
// then the operation and the counter update run in the stage into the result
// register. Operand reads see a write from the instruction ahead through a bypass,
// so dependent instructions also issue back to back. After reset the registers and
// counter are zero and the program length is zero, so results report finished until
// cfg_wr_data has been written.
module toy_register_machine_execute import trm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  trm_in_if.sink            in_chan,
  trm_out_if.source         out_chan,
  input  logic              cfg_wr_en,
  input  logic [PC_W-1:0]   cfg_wr_data
);

  logic               stg_valid_r, stg_valid_nxt;
  logic [FIELD_W-1:0] stg_op_r;
  logic [FIELD_W-1:0] stg_rd_r;
  logic [DATA_W-1:0]  stg_imm_r;
  logic [PC_W-1:0]    pc_r;
  logic [PC_W-1:0]    len_r;
  logic [PC_W-1:0]    len_eff;
  logic               out_valid_r, out_valid_nxt;
  exe_res_t           out_res_r;

  logic               load;
  logic               fire;
  logic [DATA_W-1:0]  opnd_a;
  logic [DATA_W-1:0]  opnd_b;
  rf_wr_t             rf_wr;
  rf_wr_t             exe_wr;
  exe_res_t           exe_res;

  assign fire            = stg_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready   = !stg_valid_r || fire;
  assign load            = in_chan.valid && in_chan.ready;
  assign stg_valid_nxt   = load ? 1'b1 : (fire ? 1'b0 : stg_valid_r);
  assign out_valid_nxt   = fire ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  assign len_eff = (int'(len_r) > PROGRAM_DEPTH) ? PC_W'(PROGRAM_DEPTH) : len_r;

  // register write only lands when the instruction leaves the stage
  always_comb begin
    rf_wr    = exe_wr;
    rf_wr.en = exe_wr.en && fire;
  end

  trm_regfile u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (load),
    .rd_a_idx (in_chan.dest_reg),
    .rd_b_idx (in_chan.source_reg),
    .wr       (rf_wr),
    .rd_a     (opnd_a),
    .rd_b     (opnd_b)
  );

  trm_alu u_alu (
    .opcode    (stg_op_r),
    .dest_reg  (stg_rd_r),
    .immediate (stg_imm_r),
    .opnd_a    (opnd_a),
    .opnd_b    (opnd_b),
    .pc        (pc_r),
    .len       (len_eff),
    .wr        (exe_wr),
    .res       (exe_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      len_r       <= '0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        pc_r <= exe_res.next_pc;
      end
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stg_op_r  <= in_chan.opcode;
      stg_rd_r  <= in_chan.dest_reg;
      stg_imm_r <= in_chan.immediate;
    end
    if (fire) begin
      out_res_r <= exe_res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.next_pc     = out_res_r.next_pc;
  assign out_chan.print_kind  = out_res_r.print_kind;
  assign out_chan.print_value = out_res_r.print_value;
  assign out_chan.finished    = out_res_r.finished;
  assign out_chan.fault       = out_res_r.fault;

endmodule

FILE: src/trm_checker.sv
// trm_checker: port-level checks on the result channel of the execute stage.
// Depends on trm_pkg; attached to toy_register_machine_execute by the bind below.
module trm_checker import trm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PC_W-1:0]   out_next_pc,
  input logic [1:0]        out_print_kind,
  input logic [DATA_W-1:0] out_print_value,
  input logic              out_finished,
  input logic              out_fault
);

  // a stalled result holds until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc)
      && $stable(out_print_value) && $stable(out_fault))
    else $error("result changed while stalled");

  // a faulting jump prints nothing and leaves the counter inside the program
  a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_print_kind == PK_NONE && !out_finished)
    else $error("fault result with print or finished");

  a_char_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_print_kind == PK_CHAR |-> out_print_value[DATA_W-1:8] == '0)
    else $error("character print wider than a byte");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_next_pc) <= PROGRAM_DEPTH)
    else $error("next counter beyond program depth");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_print_kind == PK_NONE || out_print_kind == PK_NUM
      || out_print_kind == PK_CHAR)
    else $error("unused print kind code");

endmodule

bind toy_register_machine_execute trm_checker u_trm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_next_pc     (out_chan.next_pc),
  .out_print_kind  (out_chan.print_kind),
  .out_print_value (out_chan.print_value),
  .out_finished    (out_chan.finished),
  .out_fault       (out_chan.fault)
);
